>>> rtl/core/dps_pkg.sv
// ----------------------------------------------------------------------------
// dps_pkg
// Shared constants, command and status types for the depth-to-scan block.
// ----------------------------------------------------------------------------
package dps_pkg;

  localparam int NUM_RANGES_DEF = 64;
  localparam int MAX_ROWS_DEF   = 1024;
  localparam int MAX_COLS_DEF   = 1024;

  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 3;
  localparam int ROW_W     = 10;
  localparam int COL_W     = 10;
  localparam int DEPTH_W   = 16;
  localparam int RANGE_W   = 16;
  localparam int BIN_W     = 6;
  localparam int CNT_W     = 7;
  localparam int OP_W      = 5;

  localparam int CORDIC_STEPS = 16;
  localparam logic signed [19:0] HALF_PI_Q16 = 20'sd102944;
  localparam logic [RANGE_W-1:0] EMPTY_RESET = 16'd8100;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_X_COEF  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Y_COEF  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Z_COEF  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RNG = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RNG = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_THICK   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_START   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BPR     = 3'd7;

  // Datapath operations
  localparam logic [OP_W-1:0] OP_NONE  = 5'd0;
  localparam logic [OP_W-1:0] OP_LOAD  = 5'd1;
  localparam logic [OP_W-1:0] OP_COL   = 5'd2;
  localparam logic [OP_W-1:0] OP_ROW   = 5'd3;
  localparam logic [OP_W-1:0] OP_DEP   = 5'd4;
  localparam logic [OP_W-1:0] OP_FIN   = 5'd5;
  localparam logic [OP_W-1:0] OP_SQX   = 5'd6;
  localparam logic [OP_W-1:0] OP_SQY   = 5'd7;
  localparam logic [OP_W-1:0] OP_MIN2  = 5'd8;
  localparam logic [OP_W-1:0] OP_MAX2  = 5'd9;
  localparam logic [OP_W-1:0] OP_INIT  = 5'd10;
  localparam logic [OP_W-1:0] OP_ITER  = 5'd11;
  localparam logic [OP_W-1:0] OP_BINM  = 5'd12;
  localparam logic [OP_W-1:0] OP_RD    = 5'd13;
  localparam logic [OP_W-1:0] OP_UPD   = 5'd14;
  localparam logic [OP_W-1:0] OP_EMIT  = 5'd15;
  localparam logic [OP_W-1:0] OP_CLEAR = 5'd16;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [1:0]       axis;
    logic [CNT_W-1:0] cnt;
  } cmd_t;

  typedef struct packed {
    logic skip;
    logic zdrop;
    logic rdrop;
    logic bdrop;
    logic fe;
  } status_t;

  // Arctangent of 2^-i at scale 2^-16 rad
  function automatic logic signed [19:0] atan_q16(input logic [3:0] i);
    logic signed [19:0] v;
    case (i)
      4'd0:    v = 20'sd51472;
      4'd1:    v = 20'sd30385;
      4'd2:    v = 20'sd16055;
      4'd3:    v = 20'sd8150;
      4'd4:    v = 20'sd4091;
      4'd5:    v = 20'sd2047;
      4'd6:    v = 20'sd1024;
      4'd7:    v = 20'sd512;
      4'd8:    v = 20'sd256;
      4'd9:    v = 20'sd128;
      4'd10:   v = 20'sd64;
      4'd11:   v = 20'sd32;
      4'd12:   v = 20'sd16;
      4'd13:   v = 20'sd8;
      4'd14:   v = 20'sd4;
      default: v = 20'sd2;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/core/dps_ctrl.sv
// ----------------------------------------------------------------------------
// dps_ctrl
// Sequencer: steps the datapath through projection, filtering, root/angle
// iterations, bin update and the end-of-frame scan emission.
// ----------------------------------------------------------------------------
module dps_ctrl #(
  parameter int NUM_RANGES = dps_pkg::NUM_RANGES_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  output dps_pkg::cmd_t   cmd,
  input  dps_pkg::status_t st
);
  import dps_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_COL  = 5'd1;
  localparam logic [4:0] S_ROW  = 5'd2;
  localparam logic [4:0] S_DEP  = 5'd3;
  localparam logic [4:0] S_FIN  = 5'd4;
  localparam logic [4:0] S_ZCK  = 5'd5;
  localparam logic [4:0] S_SQY  = 5'd6;
  localparam logic [4:0] S_MIN  = 5'd7;
  localparam logic [4:0] S_MAX  = 5'd8;
  localparam logic [4:0] S_RCK  = 5'd9;
  localparam logic [4:0] S_ITER = 5'd10;
  localparam logic [4:0] S_BINM = 5'd11;
  localparam logic [4:0] S_BCK  = 5'd12;
  localparam logic [4:0] S_UPD  = 5'd13;
  localparam logic [4:0] S_EMIT = 5'd14;
  localparam logic [4:0] S_LAST = 5'd15;

  localparam logic [CNT_W-1:0] LAST_BIN  = CNT_W'(NUM_RANGES - 1);
  localparam logic [CNT_W-1:0] LAST_ITER = CNT_W'(CORDIC_STEPS - 1);

  logic [4:0]       state, state_next;
  logic [1:0]       axis, axis_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [4:0]       finish;

  assign finish = st.fe ? S_EMIT : S_IDLE;
  assign busy   = (state != S_IDLE);

  always_comb begin
    state_next = state;
    axis_next  = axis;
    cnt_next   = cnt;
    cmd.op     = OP_NONE;
    cmd.axis   = axis;
    cmd.cnt    = cnt;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.op     = OP_LOAD;
          axis_next  = 2'd0;
          cnt_next   = '0;
          state_next = S_COL;
        end
      end
      S_COL: begin
        if (st.skip) begin
          state_next = finish;
        end else begin
          cmd.op     = OP_COL;
          state_next = S_ROW;
        end
      end
      S_ROW: begin
        cmd.op     = OP_ROW;
        state_next = S_DEP;
      end
      S_DEP: begin
        cmd.op     = OP_DEP;
        state_next = S_FIN;
      end
      S_FIN: begin
        cmd.op = OP_FIN;
        if (axis == 2'd2) begin
          state_next = S_ZCK;
        end else begin
          axis_next  = axis + 2'd1;
          state_next = S_COL;
        end
      end
      S_ZCK: begin
        if (st.zdrop) begin
          state_next = finish;
        end else begin
          cmd.op     = OP_SQX;
          state_next = S_SQY;
        end
      end
      S_SQY: begin
        cmd.op     = OP_SQY;
        state_next = S_MIN;
      end
      S_MIN: begin
        cmd.op     = OP_MIN2;
        state_next = S_MAX;
      end
      S_MAX: begin
        cmd.op     = OP_MAX2;
        state_next = S_RCK;
      end
      S_RCK: begin
        if (st.rdrop) begin
          state_next = finish;
        end else begin
          cmd.op     = OP_INIT;
          cnt_next   = '0;
          state_next = S_ITER;
        end
      end
      S_ITER: begin
        cmd.op = OP_ITER;
        if (cnt == LAST_ITER) begin
          cnt_next   = '0;
          state_next = S_BINM;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_BINM: begin
        cmd.op     = OP_BINM;
        state_next = S_BCK;
      end
      S_BCK: begin
        if (st.bdrop) begin
          state_next = finish;
        end else begin
          cmd.op     = OP_RD;
          state_next = S_UPD;
        end
      end
      S_UPD: begin
        cmd.op     = OP_UPD;
        state_next = finish;
      end
      S_EMIT: begin
        cmd.op = OP_EMIT;
        if (cnt == LAST_BIN) begin
          cnt_next   = '0;
          state_next = S_LAST;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_LAST: begin
        // The final beat is on the outputs while the bins are refilled.
        cmd.op     = OP_CLEAR;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      axis  <= 2'd0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      axis  <= axis_next;
      cnt   <= cnt_next;
    end
  end

endmodule

>>> rtl/core/dps_datapath.sv
// ----------------------------------------------------------------------------
// dps_datapath
// Configuration registers, shared multiplier, root and CORDIC iteration unit,
// bin memory and result registers.
// ----------------------------------------------------------------------------
module dps_datapath #(
  parameter int NUM_RANGES = dps_pkg::NUM_RANGES_DEF,
  parameter int MAX_ROWS   = dps_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS   = dps_pkg::MAX_COLS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_en,
  input  logic [dps_pkg::CFG_IDX_W-1:0]     wr_index,
  input  logic [dps_pkg::CFG_W-1:0]         wr_data,
  input  logic [dps_pkg::ROW_W-1:0]         pixel_row,
  input  logic [dps_pkg::COL_W-1:0]         pixel_col,
  input  logic [dps_pkg::DEPTH_W-1:0]       depth_mm,
  input  logic                              frame_end,
  input  dps_pkg::cmd_t                     cmd,
  output dps_pkg::status_t                  st,
  output logic                              result_strobe,
  output logic [dps_pkg::BIN_W-1:0]         bin_index,
  output logic [dps_pkg::RANGE_W-1:0]       range_mm,
  output logic                              last_bin
);
  import dps_pkg::*;

  localparam int IDX_W = (NUM_RANGES > 1) ? $clog2(NUM_RANGES) : 1;

  // Configuration
  logic [63:0] coef_x, coef_y, coef_z;
  logic [15:0] min_rng, max_rng, thick, bpr;
  logic [15:0] start_ang;

  // Working registers
  logic [ROW_W-1:0]   row_r;
  logic [COL_W-1:0]   col_r;
  logic [DEPTH_W-1:0] d_r;
  logic               fe_r;
  logic signed [29:0] acc;
  logic signed [63:0] prod;
  logic signed [25:0] px, py, pz;
  logic [51:0]        r2;
  logic [31:0]        lo2, hi2;
  logic signed [35:0] cx, cy;
  logic signed [19:0] cz;
  logic               oz;
  logic [31:0]        rem;
  logic [31:0]        res;
  logic signed [19:0] bin_r;

  // Bin store
  logic [RANGE_W-1:0]    mem [NUM_RANGES];
  logic [NUM_RANGES-1:0] vld;
  logic [RANGE_W-1:0]    empty_val;
  logic [RANGE_W-1:0]    rdq;
  logic                  vq;
  logic                  pend;
  logic [IDX_W-1:0]      pidx;

  logic [63:0]        cf;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  logic signed [63:0] rnd;
  logic signed [25:0] pt;
  logic signed [25:0] zabs;
  logic signed [20:0] rel;
  logic signed [35:0] dx, dy;
  logic [31:0]        bitv, trial;
  logic [RANGE_W-1:0] cur;
  logic [16:0]        empty_sum;
  logic [IDX_W-1:0]   baddr;

  always_comb begin
    case (cmd.axis)
      2'd0:    cf = coef_x;
      2'd1:    cf = coef_y;
      default: cf = coef_z;
    endcase
  end

  assign rel = 21'($signed(oz ? 20'sd0 : cz))
             - $signed({{2{start_ang[15]}}, start_ang, 3'b000});

  // One multiplier, shared by the projection, square, bound and bin steps
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_COL: begin
        mul_a = {{16{cf[15]}}, cf[15:0]};
        mul_b = {22'd0, col_r};
      end
      OP_ROW: begin
        mul_a = {{16{cf[31]}}, cf[31:16]};
        mul_b = {22'd0, row_r};
      end
      OP_DEP: begin
        mul_a = {{2{acc[29]}}, acc};
        mul_b = {16'd0, d_r};
      end
      OP_SQX: begin
        mul_a = {{6{px[25]}}, px};
        mul_b = {{6{px[25]}}, px};
      end
      OP_SQY: begin
        mul_a = {{6{py[25]}}, py};
        mul_b = {{6{py[25]}}, py};
      end
      OP_MIN2: begin
        mul_a = {16'd0, min_rng};
        mul_b = {16'd0, min_rng};
      end
      OP_MAX2: begin
        mul_a = {16'd0, max_rng};
        mul_b = {16'd0, max_rng};
      end
      OP_BINM: begin
        mul_a = {{11{rel[20]}}, rel};
        mul_b = {16'd0, bpr};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Round half up at 2^-23, then add the offset
  assign rnd = (prod + 64'sd4194304) >>> 23;
  assign pt  = rnd[25:0] + {{10{cf[63]}}, cf[63:48]};

  assign zabs = pz[25] ? -pz : pz;

  assign dx    = cy >>> cmd.cnt[3:0];
  assign dy    = cx >>> cmd.cnt[3:0];
  assign bitv  = 32'h4000_0000 >> {cmd.cnt[3:0], 1'b0};
  assign trial = res + bitv;

  assign cur       = vq ? rdq : empty_val;
  assign empty_sum = {1'b0, max_rng} + 17'd100;
  assign baddr     = bin_r[IDX_W-1:0];

  always_comb begin
    st.skip  = (d_r == '0) || ({3'd0, row_r} >= 13'(MAX_ROWS))
            || ({3'd0, col_r} >= 13'(MAX_COLS));
    st.zdrop = ({1'b0, zabs[24:0]} >= {10'd0, thick});
    st.rdrop = (r2 < {20'd0, lo2}) || (r2 > {20'd0, hi2});
    st.bdrop = bin_r[19] || (bin_r >= 20'sd0 + 20'(NUM_RANGES));
    st.fe    = fe_r;
  end

  // Configuration and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_x    <= '0;
      coef_y    <= '0;
      coef_z    <= '0;
      min_rng   <= 16'd300;
      max_rng   <= 16'd8000;
      thick     <= 16'd50;
      start_ang <= 16'hCDBC;
      bpr       <= 16'd1304;
      vld       <= '0;
      empty_val <= EMPTY_RESET;
      pend      <= 1'b0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_X_COEF:  coef_x    <= wr_data;
          REG_Y_COEF:  coef_y    <= wr_data;
          REG_Z_COEF:  coef_z    <= wr_data;
          REG_MIN_RNG: min_rng   <= wr_data[15:0];
          REG_MAX_RNG: max_rng   <= wr_data[15:0];
          REG_THICK:   thick     <= wr_data[15:0];
          REG_START:   start_ang <= wr_data[15:0];
          REG_BPR:     bpr       <= wr_data[15:0];
          default: begin
          end
        endcase
      end
      pend <= (cmd.op == OP_EMIT);
      if (cmd.op == OP_UPD && {1'b0, res[15:0]} < {1'b0, cur}) begin
        vld[baddr] <= 1'b1;
      end
      if (cmd.op == OP_CLEAR) begin
        vld       <= '0;
        empty_val <= empty_sum[16] ? 16'hFFFF : empty_sum[15:0];
      end
    end
  end

  // Arithmetic registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        row_r <= pixel_row;
        col_r <= pixel_col;
        d_r   <= depth_mm;
        fe_r  <= frame_end;
      end
      OP_COL:  acc  <= 30'(mul_p) + {{5{cf[47]}}, cf[47:32], 9'd0};
      OP_ROW:  acc  <= acc + 30'(mul_p);
      OP_DEP:  prod <= mul_p;
      OP_FIN: begin
        case (cmd.axis)
          2'd0:    px <= pt;
          2'd1:    py <= pt;
          default: pz <= pt;
        endcase
      end
      OP_SQX:  r2  <= mul_p[51:0];
      OP_SQY:  r2  <= r2 + mul_p[51:0];
      OP_MIN2: lo2 <= mul_p[31:0];
      OP_MAX2: hi2 <= mul_p[31:0];
      OP_INIT: begin
        // Range check bounds |x| and |y| to 16 bits here.
        oz  <= (px == '0) && (py == '0);
        rem <= r2[31:0];
        res <= '0;
        if (px[25]) begin
          if (!py[25]) begin
            cx <= {{3{py[16]}}, py[16:0], 16'd0};
            cy <= -{{3{px[16]}}, px[16:0], 16'd0};
            cz <= HALF_PI_Q16;
          end else begin
            cx <= -{{3{py[16]}}, py[16:0], 16'd0};
            cy <= {{3{px[16]}}, px[16:0], 16'd0};
            cz <= -HALF_PI_Q16;
          end
        end else begin
          cx <= {{3{px[16]}}, px[16:0], 16'd0};
          cy <= {{3{py[16]}}, py[16:0], 16'd0};
          cz <= '0;
        end
      end
      OP_ITER: begin
        if (rem >= trial) begin
          rem <= rem - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        if (cy > 0) begin
          cx <= cx + dx;
          cy <= cy - dy;
          cz <= cz + atan_q16(cmd.cnt[3:0]);
        end else begin
          cx <= cx - dx;
          cy <= cy + dy;
          cz <= cz - atan_q16(cmd.cnt[3:0]);
        end
      end
      OP_BINM: bin_r <= mul_p[41:22];
      default: begin
      end
    endcase
  end

  // Bin memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.op == OP_UPD && {1'b0, res[15:0]} < {1'b0, cur}) begin
      mem[baddr] <= res[15:0];
    end
    if (cmd.op == OP_RD) begin
      rdq <= mem[baddr];
      vq  <= vld[baddr];
    end else if (cmd.op == OP_EMIT) begin
      rdq  <= mem[cmd.cnt[IDX_W-1:0]];
      vq   <= vld[cmd.cnt[IDX_W-1:0]];
      pidx <= cmd.cnt[IDX_W-1:0];
    end
  end

  assign result_strobe = pend;
  assign bin_index     = BIN_W'(pidx);
  assign range_mm      = cur;
  assign last_bin      = (pidx == IDX_W'(NUM_RANGES - 1));

endmodule

>>> rtl/core/depth_pixels_to_scan_bins_top.sv
// ----------------------------------------------------------------------------
// depth_pixels_to_scan_bins_top
// Projects depth pixels to planar points and keeps the nearest range per
// angular bin; emits the whole scan on the frame-end pixel.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Payload
//  pixel     in         start & !busy        pixel_row, pixel_col, depth_mm,
//                                            frame_end
//  result    out        result_strobe        bin_index, range_mm, last_bin
//  config    in         wr_en                wr_index, wr_data
//
// A pixel is sequenced through the shared multiplier (twelve projection steps
// and four squares) and the 16-step root and CORDIC loop before the next one
// is accepted; pixels dropped early return sooner.
// A frame-end pixel then adds one result beat per bin, then a refill.
// Reset is synchronous; the bins then read as 8100 mm. Result beats cannot
// be stalled: each is valid for exactly one cycle.
// ----------------------------------------------------------------------------
module depth_pixels_to_scan_bins_top #(
  parameter int NUM_RANGES = dps_pkg::NUM_RANGES_DEF,
  parameter int MAX_ROWS   = dps_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS   = dps_pkg::MAX_COLS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          wr_en,
  input  logic [dps_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [dps_pkg::CFG_W-1:0]     wr_data,
  input  logic [dps_pkg::ROW_W-1:0]     pixel_row,
  input  logic [dps_pkg::COL_W-1:0]     pixel_col,
  input  logic [dps_pkg::DEPTH_W-1:0]   depth_mm,
  input  logic                          frame_end,
  output logic                          result_strobe,
  output logic [dps_pkg::BIN_W-1:0]     bin_index,
  output logic [dps_pkg::RANGE_W-1:0]   range_mm,
  output logic                          last_bin
);
  import dps_pkg::*;

  cmd_t    cmd;
  status_t st;

  dps_ctrl #(
    .NUM_RANGES(NUM_RANGES)
  ) u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .cmd  (cmd),
    .st   (st)
  );

  dps_datapath #(
    .NUM_RANGES(NUM_RANGES),
    .MAX_ROWS  (MAX_ROWS),
    .MAX_COLS  (MAX_COLS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data),
    .pixel_row    (pixel_row),
    .pixel_col    (pixel_col),
    .depth_mm     (depth_mm),
    .frame_end    (frame_end),
    .cmd          (cmd),
    .st           (st),
    .result_strobe(result_strobe),
    .bin_index    (bin_index),
    .range_mm     (range_mm),
    .last_bin     (last_bin)
  );

endmodule
